// File: sv/hafr_pkg.sv
// ----------------------------------------------------------------------------
// hafr_pkg
// Shared types and constants for the hex ascii frame receiver: item structs,
// configuration codes, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package hafr_pkg;

  localparam int unsigned FRAME_CAPACITY = 64;
  localparam int unsigned LEN_W          = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned IDX_W          = 7;
  localparam int unsigned FLAGS_W        = 5;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR      = 1'b1;

  localparam logic [7:0] SEED_RESET     = 8'h55;
  localparam logic [7:0] END_CHAR_RESET = 8'h0a;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_CHAR  = 1'b1;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] HEX_TEN      = 8'h0a;

  localparam int unsigned FLAG_DANGLING  = 0;
  localparam int unsigned FLAG_RUNT      = 1;
  localparam int unsigned FLAG_CHECKSUM  = 2;
  localparam int unsigned FLAG_BAD_CHAR  = 3;
  localparam int unsigned FLAG_TRUNCATED = 4;

  localparam int unsigned MIN_FRAME_LEN = 2;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         data_byte;
    logic [IDX_W-1:0]   byte_index;
    logic [FLAGS_W-1:0] end_flags;
    logic               frame_ok;
    logic [CNT_W-1:0]   good_frames;
    logic [CNT_W-1:0]   bad_frames;
    logic [CNT_W-1:0]   checksum_errors;
    logic [CNT_W-1:0]   runt_frames;
    logic [CNT_W-1:0]   bad_characters;
    logic [CNT_W-1:0]   dangling_nibbles;
  } out_item_t;

  typedef struct packed {
    logic [7:0] checksum_seed;
    logic [7:0] end_char;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_nib_t;

  function automatic hex_nib_t hex_digit(input logic [7:0] c);
    hex_nib_t   r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      t       = c - CHAR_DIGIT_0;
      r.valid = 1'b1;
      r.value = t[3:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      t       = c - CHAR_UPPER_A + HEX_TEN;
      r.valid = 1'b1;
      r.value = t[3:0];
    end
    return r;
  endfunction

endpackage

// File: sv/hafr_cfg.sv
// ----------------------------------------------------------------------------
// hafr_cfg
// Configuration registers: checksum seed and end-of-frame character.
// ----------------------------------------------------------------------------
module hafr_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hafr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hafr_pkg::CFG_DATA_W-1:0] cfg_data,
  output hafr_pkg::cfg_t                  cfg
);

  hafr_pkg::cfg_t cfg_r;
  hafr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        hafr_pkg::CFG_CHECKSUM_SEED: cfg_nxt.checksum_seed = cfg_data[7:0];
        hafr_pkg::CFG_END_CHAR:      cfg_nxt.end_char      = cfg_data[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.checksum_seed <= hafr_pkg::SEED_RESET;
      cfg_r.end_char      <= hafr_pkg::END_CHAR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/hafr_engine.sv
// ----------------------------------------------------------------------------
// hafr_engine
// Frame state and event counters. Decodes one registered character per
// enabled cycle and forms the byte or end-of-frame result.
// ----------------------------------------------------------------------------
module hafr_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  hafr_pkg::in_item_t  item,
  input  hafr_pkg::cfg_t      cfg,
  output logic                res_valid,
  output hafr_pkg::out_item_t res
);

  logic [7:0]                 sum_r,      sum_nxt;
  logic                       exp_low_r,  exp_low_nxt;
  logic [3:0]                 hold_r,     hold_nxt;
  logic                       err_r,      err_nxt;
  logic [hafr_pkg::LEN_W-1:0] len_r,      len_nxt;
  logic                       trunc_r,    trunc_nxt;
  logic [hafr_pkg::CNT_W-1:0] good_r,     good_nxt;
  logic [hafr_pkg::CNT_W-1:0] bad_r,      bad_nxt;
  logic [hafr_pkg::CNT_W-1:0] chk_r,      chk_nxt;
  logic [hafr_pkg::CNT_W-1:0] runt_r,     runt_nxt;
  logic [hafr_pkg::CNT_W-1:0] badch_r,    badch_nxt;
  logic [hafr_pkg::CNT_W-1:0] dang_r,     dang_nxt;

  hafr_pkg::hex_nib_t           nib;
  logic [7:0]                   byte_val;
  logic [hafr_pkg::FLAGS_W-1:0] flags;

  always_comb begin
    nib       = hafr_pkg::hex_digit(item.char_code);
    byte_val  = {hold_r, nib.value};
    flags     = '0;
    sum_nxt   = sum_r;
    exp_low_nxt = exp_low_r;
    hold_nxt  = hold_r;
    err_nxt   = err_r;
    len_nxt   = len_r;
    trunc_nxt = trunc_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    chk_nxt   = chk_r;
    runt_nxt  = runt_r;
    badch_nxt = badch_r;
    dang_nxt  = dang_r;
    res_valid = 1'b0;
    res       = '0;

    if (fire) begin
      if (item.action == hafr_pkg::ACT_START) begin
        sum_nxt     = cfg.checksum_seed;
        exp_low_nxt = 1'b1;
        hold_nxt    = '0;
        err_nxt     = 1'b0;
        len_nxt     = '0;
        trunc_nxt   = 1'b0;
      end else if (item.char_code == cfg.end_char) begin
        flags[hafr_pkg::FLAG_BAD_CHAR] = err_r;
        if (exp_low_r) begin
          err_nxt  = 1'b1;
          dang_nxt = dang_r + 1'b1;
          flags[hafr_pkg::FLAG_DANGLING] = 1'b1;
        end
        if (len_r < hafr_pkg::LEN_W'(hafr_pkg::MIN_FRAME_LEN)) begin
          runt_nxt = runt_r + 1'b1;
          bad_nxt  = bad_nxt + 1'b1;
          err_nxt  = 1'b1;
          flags[hafr_pkg::FLAG_RUNT] = 1'b1;
        end
        if (sum_r != 8'd0) begin
          chk_nxt = chk_r + 1'b1;
          bad_nxt = bad_nxt + 1'b1;
          err_nxt = 1'b1;
          flags[hafr_pkg::FLAG_CHECKSUM] = 1'b1;
        end
        flags[hafr_pkg::FLAG_TRUNCATED] = trunc_r;
        if (!err_nxt) begin
          good_nxt = good_r + 1'b1;
        end
        res_valid      = 1'b1;
        res.kind       = hafr_pkg::KIND_STATUS;
        res.byte_index = hafr_pkg::IDX_W'(len_r);
        res.end_flags  = flags;
        res.frame_ok   = !err_nxt && !trunc_r;
      end else if (!nib.valid) begin
        badch_nxt = badch_r + 1'b1;
        if (!err_r) begin
          bad_nxt = bad_r + 1'b1;
          err_nxt = 1'b1;
        end
      end else if (!exp_low_r) begin
        hold_nxt    = nib.value;
        exp_low_nxt = 1'b1;
      end else begin
        if (len_r < hafr_pkg::LEN_W'(hafr_pkg::FRAME_CAPACITY)) begin
          len_nxt = len_r + 1'b1;
        end else begin
          trunc_nxt = 1'b1;
        end
        sum_nxt        = sum_r - byte_val;
        exp_low_nxt    = 1'b0;
        res_valid      = 1'b1;
        res.kind       = hafr_pkg::KIND_BYTE;
        res.data_byte  = byte_val;
        res.byte_index = hafr_pkg::IDX_W'(len_r);
      end
    end

    res.good_frames      = good_nxt;
    res.bad_frames       = bad_nxt;
    res.checksum_errors  = chk_nxt;
    res.runt_frames      = runt_nxt;
    res.bad_characters   = badch_nxt;
    res.dangling_nibbles = dang_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= hafr_pkg::SEED_RESET;
      exp_low_r <= 1'b1;
      hold_r    <= '0;
      err_r     <= 1'b0;
      len_r     <= '0;
      trunc_r   <= 1'b0;
      good_r    <= '0;
      bad_r     <= '0;
      chk_r     <= '0;
      runt_r    <= '0;
      badch_r   <= '0;
      dang_r    <= '0;
    end else begin
      sum_r     <= sum_nxt;
      exp_low_r <= exp_low_nxt;
      hold_r    <= hold_nxt;
      err_r     <= err_nxt;
      len_r     <= len_nxt;
      trunc_r   <= trunc_nxt;
      good_r    <= good_nxt;
      bad_r     <= bad_nxt;
      chk_r     <= chk_nxt;
      runt_r    <= runt_nxt;
      badch_r   <= badch_nxt;
      dang_r    <= dang_nxt;
    end
  end

endmodule

// File: sv/hex_ascii_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// hex_ascii_frame_receiver_core
// Hex ascii frame receiver: decodes hex digit pairs into bytes with a
// subtractive checksum and reports end-of-frame status with event counters.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item  (action, char_code)
//   out      output     out_valid/ out_stall out_item (byte or status)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// one character per cycle while the result is not stalled; from input transfer
// to result: input register, then result register after the frame state update
// synchronous active-low reset restores the registers and clears all counters
// a stalled result holds the pipeline; the input register still takes one
// character while the result waits
// ----------------------------------------------------------------------------
module hex_ascii_frame_receiver_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hafr_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hafr_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [hafr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hafr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                s1_valid_r;
  hafr_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  hafr_pkg::out_item_t out_item_r;
  logic                advance;
  logic                fire;
  logic                res_valid;
  hafr_pkg::out_item_t res;
  hafr_pkg::cfg_t      cfg;

  hafr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  hafr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: tb/hex_ascii_frame_receiver_core_checker.sv
// ----------------------------------------------------------------------------
// hex_ascii_frame_receiver_core_checker
// Watches the input, result and configuration ports of the frame receiver.
// It keeps its own copy of the frame state, the counters and the registers,
// and works out any byte or status result of each input transfer. Each
// result transfer is compared field by field with the oldest expected result.
// Mismatches are counted and the count is handed to the testbench top.
// ----------------------------------------------------------------------------
module hex_ascii_frame_receiver_core_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  hafr_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  hafr_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [hafr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hafr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  seed_copy;
  logic [7:0]  end_copy;
  logic [7:0]  csum;
  logic        want_low;
  logic [3:0]  hi_hold;
  logic        in_err;
  int unsigned flen;
  logic        trunc;
  logic [31:0] n_good, n_bad, n_csum, n_runt, n_badch, n_dangle;

  hafr_pkg::out_item_t decoded_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  function automatic void clear_frame_state();
    csum     = seed_copy;
    want_low = 1'b1;
    hi_hold  = '0;
    in_err   = 1'b0;
    flen     = 0;
    trunc    = 1'b0;
  endfunction

  // returns 1 when the transfer produces a result
  function automatic bit decode_char(hafr_pkg::in_item_t it,
                                     output hafr_pkg::out_item_t r);
    logic [7:0] c;
    logic [7:0] b;
    logic [3:0] nib;
    bit         is_hex;
    bit         emit;
    c      = it.char_code;
    r      = '0;
    emit   = 1'b0;
    is_hex = 1'b0;
    nib    = '0;
    if (it.action == hafr_pkg::ACT_START) begin
      clear_frame_state();
      return 1'b0;
    end
    if (c == end_copy) begin
      if (in_err)
        r.end_flags[hafr_pkg::FLAG_BAD_CHAR] = 1'b1;
      if (want_low) begin
        in_err = 1'b1;
        n_dangle++;
        r.end_flags[hafr_pkg::FLAG_DANGLING] = 1'b1;
      end
      if (flen < hafr_pkg::MIN_FRAME_LEN) begin
        n_runt++;
        n_bad++;
        in_err = 1'b1;
        r.end_flags[hafr_pkg::FLAG_RUNT] = 1'b1;
      end
      if (csum != 8'h00) begin
        n_csum++;
        n_bad++;
        in_err = 1'b1;
        r.end_flags[hafr_pkg::FLAG_CHECKSUM] = 1'b1;
      end
      if (trunc)
        r.end_flags[hafr_pkg::FLAG_TRUNCATED] = 1'b1;
      if (!in_err)
        n_good++;
      r.kind       = hafr_pkg::KIND_STATUS;
      r.byte_index = hafr_pkg::IDX_W'(flen);
      r.frame_ok   = !in_err && !trunc;
      emit         = 1'b1;
    end else begin
      if (c >= hafr_pkg::CHAR_DIGIT_0 && c <= hafr_pkg::CHAR_DIGIT_9) begin
        is_hex = 1'b1;
        nib    = c[3:0];
      end else if (c >= hafr_pkg::CHAR_UPPER_A && c <= hafr_pkg::CHAR_UPPER_F) begin
        is_hex = 1'b1;
        nib    = c[3:0] + 4'd9;
      end
      if (!is_hex) begin
        n_badch++;
        if (!in_err) begin
          n_bad++;
          in_err = 1'b1;
        end
      end else if (!want_low) begin
        hi_hold  = nib;
        want_low = 1'b1;
      end else begin
        b            = {hi_hold, nib};
        r.kind       = hafr_pkg::KIND_BYTE;
        r.data_byte  = b;
        r.byte_index = hafr_pkg::IDX_W'(flen);
        if (flen < hafr_pkg::FRAME_CAPACITY)
          flen++;
        else
          trunc = 1'b1;
        csum     = csum - b;
        want_low = 1'b0;
        emit     = 1'b1;
      end
    end
    r.good_frames      = n_good;
    r.bad_frames       = n_bad;
    r.checksum_errors  = n_csum;
    r.runt_frames      = n_runt;
    r.bad_characters   = n_badch;
    r.dangling_nibbles = n_dangle;
    return emit;
  endfunction

  always @(posedge clk) begin
    hafr_pkg::out_item_t want;
    hafr_pkg::out_item_t r;
    if (!rst_n) begin
      seed_copy = hafr_pkg::SEED_RESET;
      end_copy  = hafr_pkg::END_CHAR_RESET;
      clear_frame_state();
      n_good   = '0;
      n_bad    = '0;
      n_csum   = '0;
      n_runt   = '0;
      n_badch  = '0;
      n_dangle = '0;
      decoded_q.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (decoded_q.size() == 0) begin
          report("result transfer with no result expected");
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", out_item.kind, want.kind);
          check_field("data_byte", out_item.data_byte, want.data_byte);
          check_field("byte_index", out_item.byte_index, want.byte_index);
          check_field("end_flags", out_item.end_flags, want.end_flags);
          check_field("frame_ok", out_item.frame_ok, want.frame_ok);
          check_field("good_frames", out_item.good_frames, want.good_frames);
          check_field("bad_frames", out_item.bad_frames, want.bad_frames);
          check_field("checksum_errors", out_item.checksum_errors,
                      want.checksum_errors);
          check_field("runt_frames", out_item.runt_frames, want.runt_frames);
          check_field("bad_characters", out_item.bad_characters,
                      want.bad_characters);
          check_field("dangling_nibbles", out_item.dangling_nibbles,
                      want.dangling_nibbles);
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (decode_char(in_item, r))
          decoded_q = {decoded_q, r};
      end
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          hafr_pkg::CFG_CHECKSUM_SEED: seed_copy = cfg_data;
          hafr_pkg::CFG_END_CHAR:      end_copy  = cfg_data;
          default: ;
        endcase
      end
    end
    pending = decoded_q.size();
  end

endmodule

// File: tb/hex_ascii_frame_receiver_core_test.sv
// ----------------------------------------------------------------------------
// hex_ascii_frame_receiver_core_test
// Drives the frame receiver with a short directed frame sequence and then
// random frames: mostly well-formed frames with random bytes and lengths,
// the rest broken frames and random characters. Six phases change the
// checksum seed and end character and the idle pattern of both channels.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module hex_ascii_frame_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 325;
  localparam int NUM_PHASES      = 6;
  localparam int SETTLE_CYCLES   = 8;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  hafr_pkg::in_item_t              in_item;
  logic                            out_valid;
  logic                            out_stall;
  hafr_pkg::out_item_t             out_item;
  logic                            cfg_we;
  logic [hafr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hafr_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              fail_count;
  int                              pending;

  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_left;
  int         sent;
  logic [7:0] cur_seed;
  logic [7:0] cur_end;

  hex_ascii_frame_receiver_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hex_ascii_frame_receiver_core_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("hex_ascii_frame_receiver_core test failed");
    $finish;
  end

  // receiver side: random stall, or a long hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < hafr_pkg::HEX_TEN)
      return hafr_pkg::CHAR_DIGIT_0 + n;
    return hafr_pkg::CHAR_UPPER_A + (n - hafr_pkg::HEX_TEN);
  endfunction

  function automatic logic [7:0] pick_bad_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while ((c >= hafr_pkg::CHAR_DIGIT_0 && c <= hafr_pkg::CHAR_DIGIT_9) ||
               (c >= hafr_pkg::CHAR_UPPER_A && c <= hafr_pkg::CHAR_UPPER_F) ||
               c == cur_end);
    return c;
  endfunction

  task automatic send_item(logic act, logic [7:0] c);
    hafr_pkg::in_item_t it;
    it.action    = act;
    it.char_code = c;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(hafr_pkg::ACT_CHAR, hex_char(b[7:4]));
    send_item(hafr_pkg::ACT_CHAR, hex_char(b[3:0]));
  endtask

  // drop valid, wait for every expected result and let the pipeline settle
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [hafr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == hafr_pkg::CFG_CHECKSUM_SEED)
      cur_seed = val;
    else
      cur_end = val;
  endtask

  task automatic send_frame();
    int unsigned kind_sel;
    int unsigned len_sel;
    int          nbytes;
    int          bad_pos;
    logic [3:0]  cmd;
    logic [7:0]  sum;
    logic [7:0]  b;
    bit          broken;
    bit          fix_sum;
    bit          skip_start;
    bit          dangle;
    bit          dbl_end;
    kind_sel = $urandom_range(99);
    if (kind_sel >= 88) begin
      // loose random characters and start actions
      repeat ($urandom_range(6, 1))
        send_item(logic'($urandom_range(1)), 8'($urandom));
      return;
    end
    broken  = (kind_sel >= 70);
    len_sel = $urandom_range(99);
    if (len_sel < 4)
      nbytes = $urandom_range(70, 60);
    else if (len_sel < 14)
      nbytes = $urandom_range(1);
    else
      nbytes = $urandom_range(6, 1);
    fix_sum    = !broken || ($urandom_range(1) == 0);
    skip_start = broken && ($urandom_range(3) == 0);
    dangle     = broken && ($urandom_range(3) == 0);
    dbl_end    = broken && ($urandom_range(3) == 0);
    bad_pos    = (broken && $urandom_range(1) == 0) ? $urandom_range(nbytes) : -1;
    sum        = cur_seed;
    if (!skip_start)
      send_item(hafr_pkg::ACT_START, 8'($urandom));
    cmd = 4'($urandom);
    send_item(hafr_pkg::ACT_CHAR, hex_char(cmd));
    sum = sum - cmd;
    for (int i = 0; i < nbytes; i++) begin
      if (i == bad_pos)
        send_item(hafr_pkg::ACT_CHAR, pick_bad_char());
      b   = (fix_sum && i == nbytes - 1) ? sum : 8'($urandom);
      sum = sum - b;
      send_byte(b);
    end
    if (bad_pos == nbytes)
      send_item(hafr_pkg::ACT_CHAR, pick_bad_char());
    if (dangle)
      send_item(hafr_pkg::ACT_CHAR, hex_char(4'($urandom)));
    send_item(hafr_pkg::ACT_CHAR, cur_end);
    if (dbl_end)
      send_item(hafr_pkg::ACT_CHAR, cur_end);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_idle_pct = 20;
    rx_idle_pct = 87;
    hold_left   = 0;
    sent        = 0;
    cur_seed    = hafr_pkg::SEED_RESET;
    cur_end     = hafr_pkg::END_CHAR_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // good frame with the reset seed: command 0, then FF A9 AD
    send_item(hafr_pkg::ACT_START, 8'h00);
    send_item(hafr_pkg::ACT_CHAR, hex_char(4'h0));
    send_byte(8'hff);
    send_byte(8'ha9);
    send_byte(8'had);
    send_item(hafr_pkg::ACT_CHAR, cur_end);
    // non-hex characters around the accepted ranges, lower case, extremes
    send_item(hafr_pkg::ACT_CHAR, 8'h47);
    send_item(hafr_pkg::ACT_CHAR, 8'h2f);
    send_item(hafr_pkg::ACT_CHAR, 8'h3a);
    send_item(hafr_pkg::ACT_CHAR, 8'h40);
    send_item(hafr_pkg::ACT_CHAR, 8'h61);
    send_item(hafr_pkg::ACT_CHAR, 8'h00);
    send_item(hafr_pkg::ACT_CHAR, 8'hff);
    send_item(hafr_pkg::ACT_CHAR, cur_end);
    // empty frame, then a runt frame ending on a lone high nibble
    send_item(hafr_pkg::ACT_START, 8'hff);
    send_item(hafr_pkg::ACT_CHAR, cur_end);
    send_item(hafr_pkg::ACT_START, 8'h00);
    send_item(hafr_pkg::ACT_CHAR, hex_char(4'h5));
    send_item(hafr_pkg::ACT_CHAR, hex_char(4'h3));
    send_item(hafr_pkg::ACT_CHAR, cur_end);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_results_done();
        case (p)
          1: begin
            write_reg(hafr_pkg::CFG_CHECKSUM_SEED, 8'h00);
            write_reg(hafr_pkg::CFG_END_CHAR, 8'hff);
          end
          2: begin
            write_reg(hafr_pkg::CFG_CHECKSUM_SEED, 8'hff);
            write_reg(hafr_pkg::CFG_END_CHAR, 8'h00);
          end
          3: begin
            write_reg(hafr_pkg::CFG_CHECKSUM_SEED, 8'($urandom));
            write_reg(hafr_pkg::CFG_END_CHAR, hex_char(4'($urandom)));
          end
          4: begin
            write_reg(hafr_pkg::CFG_CHECKSUM_SEED, 8'($urandom));
            write_reg(hafr_pkg::CFG_END_CHAR, 8'($urandom));
          end
          default: begin
            write_reg(hafr_pkg::CFG_CHECKSUM_SEED, hafr_pkg::SEED_RESET);
            write_reg(hafr_pkg::CFG_END_CHAR, hafr_pkg::END_CHAR_RESET);
          end
        endcase
      end
      case (p / 2)
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 1 || p == 4)
        hold_left = 300;
      while (sent < (p + 1) * ITEMS_PER_PHASE) begin
        send_frame();
        if (p == 2 && sent >= 2 * ITEMS_PER_PHASE + ITEMS_PER_PHASE / 2 &&
            sent < 2 * ITEMS_PER_PHASE + ITEMS_PER_PHASE / 2 + 4)
          wait_results_done();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("hex_ascii_frame_receiver_core test passed");
    else
      $display("hex_ascii_frame_receiver_core test failed");
    $finish;
  end

endmodule
